// ----- design/mexp_pkg.sv -----
// Shared constants and types for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

    localparam int BASE_W    = 32;
    localparam int EXP_W     = 16;
    localparam int MOD_W     = 16;
    localparam int CNT_W     = $clog2(BASE_W);
    localparam int S_TDATA_W = BASE_W + EXP_W + MOD_W;
    localparam int M_TDATA_W = MOD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NEXT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- design/modular_exponentiation.sv -----
// Modular exponentiation by right-to-left square-and-multiply on one shared reducer.
// A zero modulus goes straight to the done state; otherwise the base is reduced one bit
// at a time, then each exponent bit, lowest first, takes a multiply into the result if
// set and always a square of the base power, each on the single double-and-add reducer.
// The result waits in the done state while the output register is full. A new request
// is taken only in idle; i_rst_n (synchronous, low) empties the block.
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // base_value [31:0], exponent [47:32], modulus [63:48]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // power_residue [15:0]
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // bad_modulus [0]
    output logic                      m_axis_tuser
);

    // Sequencer state.
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt,   n_cnt;

    // Working operands. r_shift feeds the reducer one bit per cycle from its top:
    // the full base during reduction, the multiplier left-aligned during a multiply.
    logic [BASE_W-1:0]    r_shift, n_shift;
    logic [MOD_W-1:0]     r_r,     n_r;      // partial remainder
    logic [MOD_W-1:0]     r_a,     n_a;      // multiplicand
    logic [MOD_W-1:0]     r_acc,   n_acc;    // running result
    logic [MOD_W-1:0]     r_base,  n_base;   // current base power
    logic [EXP_W-1:0]     r_exp,   n_exp;    // exponent bits not yet used
    logic [MOD_W-1:0]     r_mod,   n_mod;
    logic                 r_bad,   n_bad;

    // Output register, so a finished result can wait while a new request comes in.
    logic                 r_ovalid, n_ovalid;
    logic [MOD_W-1:0]     r_res,    n_res;
    logic                 r_obad,   n_obad;

    // Input fields.
    logic [BASE_W-1:0]    w_in_base;
    logic [EXP_W-1:0]     w_in_exp;
    logic [MOD_W-1:0]     w_in_mod;

    // Shared reducer: r <- ((2r mod m) + addend) mod m, valid for r < m and addend <= m.
    logic [MOD_W-1:0]     w_addend;
    logic [MOD_W:0]       w_dbl, w_dbl_red, w_sum, w_sum_red, w_mod_ext;
    logic [MOD_W-1:0]     w_step;

    assign w_in_base = s_axis_tdata[BASE_W-1:0];
    assign w_in_exp  = s_axis_tdata[BASE_W+EXP_W-1:BASE_W];
    assign w_in_mod  = s_axis_tdata[S_TDATA_W-1:BASE_W+EXP_W];

    always_comb begin
        // While reducing the base, the next base bit is added; while multiplying,
        // the multiplicand is added when the next multiplier bit is set.
        if (r_state == ST_REDUCE) begin
            w_addend = {{(MOD_W-1){1'b0}}, r_shift[BASE_W-1]};
        end else begin
            w_addend = r_shift[BASE_W-1] ? r_a : '0;
        end
        w_mod_ext = {1'b0, r_mod};
        w_dbl     = {r_r, 1'b0};
        w_dbl_red = (w_dbl >= w_mod_ext) ? (w_dbl - w_mod_ext) : w_dbl;
        w_sum     = w_dbl_red + {1'b0, w_addend};
        w_sum_red = (w_sum >= w_mod_ext) ? (w_sum - w_mod_ext) : w_sum;
        w_step    = w_sum_red[MOD_W-1:0];
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_res;
    assign m_axis_tuser  = r_obad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_shift <= n_shift;
        r_r     <= n_r;
        r_a     <= n_a;
        r_acc   <= n_acc;
        r_base  <= n_base;
        r_exp   <= n_exp;
        r_mod   <= n_mod;
        r_bad   <= n_bad;
        r_res   <= n_res;
        r_obad  <= n_obad;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_r      = r_r;
        n_a      = r_a;
        n_acc    = r_acc;
        n_base   = r_base;
        n_exp    = r_exp;
        n_mod    = r_mod;
        n_bad    = r_bad;
        n_res    = r_res;
        n_obad   = r_obad;
        n_ovalid = r_ovalid;

        // The downstream side takes the waiting result.
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mod   = w_in_mod;
                    n_exp   = w_in_exp;
                    n_shift = w_in_base;
                    n_r     = '0;
                    n_cnt   = CNT_W'(BASE_W - 1);
                    // The result starts at 1 mod m, which is 0 for a modulus of one.
                    n_acc   = (w_in_mod == MOD_W'(1)) ? '0 : MOD_W'(1);
                    if (w_in_mod == '0) begin
                        // No division is attempted; the result is forced to zero.
                        n_bad   = 1'b1;
                        n_acc   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_bad   = 1'b0;
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                n_r     = w_step;
                n_shift = r_shift << 1;
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_base  = w_step;
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_exp == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_r     = '0;
                    n_cnt   = CNT_W'(MOD_W - 1);
                    n_shift = {r_base, {(BASE_W-MOD_W){1'b0}}};
                    if (r_exp[0]) begin
                        n_a     = r_acc;
                        n_state = ST_MUL;
                    end else begin
                        n_a     = r_base;
                        n_state = ST_SQR;
                    end
                end
            end
            ST_MUL: begin
                n_r     = w_step;
                n_shift = r_shift << 1;
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    // Product done; set up the square of the base power.
                    n_acc   = w_step;
                    n_r     = '0;
                    n_a     = r_base;
                    n_shift = {r_base, {(BASE_W-MOD_W){1'b0}}};
                    n_cnt   = CNT_W'(MOD_W - 1);
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                n_r     = w_step;
                n_shift = r_shift << 1;
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_base  = w_step;
                    n_exp   = r_exp >> 1;
                    n_state = ST_NEXT;
                end
            end
            ST_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_ovalid || m_axis_tready) begin
                    n_res    = r_acc;
                    n_obad   = r_bad;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/mexp_checker.sv -----
// Port-level assertions for the modular exponentiation block, bound to its top level.
`default_nettype none

module mexp_checker
    import mexp_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser
);

    // A flagged modulus always comes with a zero residue.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("bad modulus result carries a nonzero residue");

    // Once a request is taken the block is busy for at least the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("block took a request while still working");

    // A new result appears only as the block goes back to waiting for requests.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result appeared while the block was busy");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

`default_nettype wire
